// ----- rtl/radial_binned_average_core_defines.svh -----
// ----------------------------------------------------------------------------
// radial binned average assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef RADIAL_BINNED_AVERAGE_CORE_DEFINES_SVH
`define RADIAL_BINNED_AVERAGE_CORE_DEFINES_SVH

// implication checked in the same cycle
`define RBA_ASSERT_NOW(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("rba assertion failed");

// implication checked in the next cycle
`define RBA_ASSERT_NEXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("rba assertion failed");

`endif

// ----- rtl/rba_pkg.sv -----
// ----------------------------------------------------------------------------
// rba_pkg
// types and constants shared by the radial binned average modules
// ----------------------------------------------------------------------------
package rba_pkg;

	typedef enum logic [1:0] {
		ACT_ACCUM = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		RES_ZERO = 2'd0,
		RES_SEL  = 2'd1,
		RES_ACC  = 2'd2,
		RES_MEAN = 2'd3
	} res_kind_t;

	localparam logic CFG_BIN_WIDTH = 1'b0;
	localparam logic CFG_RADIUS    = 1'b1;

	localparam logic [23:0] BIN_WIDTH_RST = 24'd1311;
	localparam logic [23:0] RADIUS_RST    = 24'd131072;

	localparam logic [5:0] SQRT_LAST_STEP = 6'd23;
	localparam logic [5:0] DIV_LAST_STEP  = 6'd47;

	typedef struct packed {
		logic      load;
		logic      diff;
		logic      square;
		logic      sqrt_init;
		logic      sqrt_step;
		logic      div_init_bin;
		logic      div_init_mean;
		logic      div_step;
		logic      rd_acc;
		logic      rd_sel;
		logic      wr_acc;
		logic      clr_init;
		logic      clr_step;
		logic      emit;
		res_kind_t res;
	} cmd_t;

	typedef struct packed {
		action_t action;
		logic    reject;
		logic    step_last;
		logic    bin_over;
		logic    sel_over;
		logic    cnt_zero;
		logic    clr_last;
	} sts_t;

endpackage

// ----- rtl/rba_ctrl.sv -----
// ----------------------------------------------------------------------------
// rba_ctrl
// sequencer for accumulate, read and clear items
// ----------------------------------------------------------------------------
module rba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rba_pkg::sts_t sts,
	output rba_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_DIFF,
		S_SQUARE,
		S_CHECK,
		S_SQRT,
		S_BINIT,
		S_BDIV,
		S_BCHK,
		S_AWAIT,
		S_RSEL,
		S_RWAIT,
		S_RDIV,
		S_RFIN
	} state_t;

	state_t state_q, state_d;
	logic   item_q;
	logic   done_q;

	always_comb begin
		cmd     = '0;
		cmd.res = rba_pkg::RES_ZERO;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (sts.action)
						rba_pkg::ACT_ACCUM: state_d = S_DIFF;
						rba_pkg::ACT_READ:  state_d = S_RSEL;
						rba_pkg::ACT_CLEAR: begin
							cmd.clr_init = 1'b1;
							state_d      = S_CLEAR;
						end
						default: cmd.emit = 1'b1;
					endcase
				end
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					cmd.emit = item_q;
					state_d  = S_IDLE;
				end
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_SQUARE;
			end
			S_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = S_CHECK;
			end
			S_CHECK: begin
				if (sts.reject) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end else begin
					cmd.sqrt_init = 1'b1;
					state_d       = S_SQRT;
				end
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (sts.step_last) begin
					state_d = S_BINIT;
				end
			end
			S_BINIT: begin
				cmd.div_init_bin = 1'b1;
				state_d          = S_BDIV;
			end
			S_BDIV: begin
				cmd.div_step = 1'b1;
				if (sts.step_last) begin
					state_d = S_BCHK;
				end
			end
			S_BCHK: begin
				if (sts.bin_over) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end else begin
					cmd.rd_acc = 1'b1;
					state_d    = S_AWAIT;
				end
			end
			S_AWAIT: begin
				cmd.wr_acc = 1'b1;
				cmd.emit   = 1'b1;
				cmd.res    = rba_pkg::RES_ACC;
				state_d    = S_IDLE;
			end
			S_RSEL: begin
				if (sts.sel_over) begin
					cmd.emit = 1'b1;
					cmd.res  = rba_pkg::RES_SEL;
					state_d  = S_IDLE;
				end else begin
					cmd.rd_sel = 1'b1;
					state_d    = S_RWAIT;
				end
			end
			S_RWAIT: begin
				if (sts.cnt_zero) begin
					cmd.emit = 1'b1;
					cmd.res  = rba_pkg::RES_SEL;
					state_d  = S_IDLE;
				end else begin
					cmd.div_init_mean = 1'b1;
					state_d           = S_RDIV;
				end
			end
			S_RDIV: begin
				cmd.div_step = 1'b1;
				if (sts.step_last) begin
					state_d = S_RFIN;
				end
			end
			S_RFIN: begin
				cmd.emit = 1'b1;
				cmd.res  = rba_pkg::RES_MEAN;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			item_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.emit;
			if (cmd.load) begin
				item_q <= 1'b1;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ----- rtl/rba_datapath.sv -----
// ----------------------------------------------------------------------------
// rba_datapath
// distance, square root, shared divider, bin stores and result registers
// ----------------------------------------------------------------------------
module rba_datapath #(
	parameter int NUM_BINS = 100
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rba_pkg::cmd_t       cmd,
	output rba_pkg::sts_t       sts,
	input  logic [1:0]          action,
	input  logic [15:0]         row_index,
	input  logic [15:0]         col_index,
	input  logic signed [23:0]  first_x,
	input  logic signed [23:0]  first_y,
	input  logic signed [23:0]  second_x,
	input  logic signed [23:0]  second_y,
	input  logic signed [31:0]  pair_value,
	input  logic [6:0]          bin_select,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [23:0]         cfg_data,
	output logic                accepted,
	output logic [6:0]          bin_used,
	output logic signed [31:0]  bin_mean,
	output logic [31:0]         bin_count
);

	localparam int BIN_W = $clog2(NUM_BINS);
	localparam logic [47:0] BINS_48 = 48'(NUM_BINS);
	localparam logic [31:0] BINS_32 = 32'(NUM_BINS);
	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

	logic [23:0] bw_q, lim_q;

	logic [15:0]        ri_q, ci_q;
	logic signed [23:0] fx_q, fy_q, sx_q, sy_q;
	logic signed [31:0] val_q;
	logic [6:0]         sel_q;

	logic [24:0] adx_q, ady_q;
	logic [49:0] sqx_q, sqy_q;
	logic [47:0] lim2_q;

	logic [47:0] rad_q;
	logic [25:0] rem_q;
	logic [23:0] root_q;

	logic [47:0] dvd_q;
	logic [31:0] dvs_q, drem_q;
	logic        neg_q;
	logic [5:0]  step_q;

	logic [BIN_W-1:0] clr_q, bin_q;

	logic signed [47:0] sum_mem [NUM_BINS];
	logic [31:0]        cnt_mem [NUM_BINS];
	logic signed [47:0] rsum_q;
	logic [31:0]        rcnt_q;

	logic               acc_q;
	logic [6:0]         used_q;
	logic signed [31:0] mean_q;
	logic [31:0]        count_q;

	logic signed [24:0] dx, dy;
	logic [50:0]        ssum;
	logic [27:0]        sq_t;
	logic [25:0]        sq_trial;
	logic               sq_ge;
	logic [32:0]        dv_t;
	logic               dv_ge;
	logic [31:0]        sel_ext;
	logic [BIN_W-1:0]   rd_addr, wr_addr;
	logic               mem_re, mem_we;
	logic [48:0]        nsum;
	logic signed [47:0] nsum_sat, wsum;
	logic [31:0]        ncnt, wcnt;
	logic [47:0]        abs_sum;
	logic [31:0]        mean_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q  <= rba_pkg::BIN_WIDTH_RST;
			lim_q <= rba_pkg::RADIUS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rba_pkg::CFG_BIN_WIDTH: bw_q  <= cfg_data;
				rba_pkg::CFG_RADIUS:    lim_q <= cfg_data;
			endcase
		end
	end

	assign dx   = 25'(fx_q) - 25'(sx_q);
	assign dy   = 25'(fy_q) - 25'(sy_q);
	assign ssum = 51'(sqx_q) + 51'(sqy_q);

	assign sq_t     = {rem_q, rad_q[47:46]};
	assign sq_trial = {root_q, 2'b01};
	assign sq_ge    = (sq_t >= 28'(sq_trial));

	assign dv_t  = {drem_q, dvd_q[47]};
	assign dv_ge = (dv_t >= {1'b0, dvs_q});

	assign abs_sum = rsum_q[47] ? 48'(-rsum_q) : 48'(rsum_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ri_q  <= row_index;
			ci_q  <= col_index;
			fx_q  <= first_x;
			fy_q  <= first_y;
			sx_q  <= second_x;
			sy_q  <= second_y;
			val_q <= pair_value;
			sel_q <= bin_select;
		end
		if (cmd.diff) begin
			adx_q <= dx[24] ? 25'(-dx) : 25'(dx);
			ady_q <= dy[24] ? 25'(-dy) : 25'(dy);
		end
		if (cmd.square) begin
			sqx_q  <= 50'(adx_q) * 50'(adx_q);
			sqy_q  <= 50'(ady_q) * 50'(ady_q);
			lim2_q <= 48'(lim_q) * 48'(lim_q);
		end
		if (cmd.sqrt_init) begin
			rad_q  <= ssum[47:0];
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q  <= {rad_q[45:0], 2'b00};
			rem_q  <= sq_ge ? 26'(sq_t - 28'(sq_trial)) : 26'(sq_t);
			root_q <= {root_q[22:0], sq_ge};
		end
		if (cmd.div_init_bin) begin
			dvd_q  <= 48'(root_q);
			dvs_q  <= 32'(bw_q);
			drem_q <= '0;
			neg_q  <= 1'b0;
		end else if (cmd.div_init_mean) begin
			dvd_q  <= abs_sum;
			dvs_q  <= rcnt_q;
			drem_q <= '0;
			neg_q  <= rsum_q[47];
		end else if (cmd.div_step) begin
			dvd_q  <= {dvd_q[46:0], dv_ge};
			drem_q <= dv_ge ? 32'(dv_t - {1'b0, dvs_q}) : dv_t[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.sqrt_init) begin
				step_q <= rba_pkg::SQRT_LAST_STEP;
			end else if (cmd.div_init_bin || cmd.div_init_mean) begin
				step_q <= rba_pkg::DIV_LAST_STEP;
			end else if (cmd.sqrt_step || cmd.div_step) begin
				step_q <= step_q - 6'd1;
			end
			if (cmd.clr_init) begin
				clr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= (clr_q == LAST_BIN) ? '0 : clr_q + BIN_W'(1);
			end
		end
	end

	// bin store
	assign sel_ext = 32'(sel_q);
	assign rd_addr = cmd.rd_sel ? sel_ext[BIN_W-1:0] : dvd_q[BIN_W-1:0];
	assign mem_re  = cmd.rd_sel || cmd.rd_acc;
	assign mem_we  = cmd.clr_step || cmd.wr_acc;
	assign wr_addr = cmd.clr_step ? clr_q : bin_q;

	assign nsum     = {rsum_q[47], rsum_q} + {{17{val_q[31]}}, val_q};
	assign nsum_sat = (nsum[48] != nsum[47]) ?
		(nsum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : nsum[47:0];
	assign ncnt     = (&rcnt_q) ? rcnt_q : rcnt_q + 32'd1;
	assign wsum     = cmd.clr_step ? '0 : nsum_sat;
	assign wcnt     = cmd.clr_step ? '0 : ncnt;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sum_mem[wr_addr] <= wsum;
			cnt_mem[wr_addr] <= wcnt;
		end
		if (mem_re) begin
			rsum_q <= sum_mem[rd_addr];
			rcnt_q <= cnt_mem[rd_addr];
			bin_q  <= rd_addr;
		end
	end

	// mean saturation
	always_comb begin
		if (!neg_q) begin
			mean_c = (dvd_q > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : dvd_q[31:0];
		end else begin
			mean_c = (dvd_q >= 48'h8000_0000) ? 32'h8000_0000 : ~dvd_q[31:0] + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.res)
				rba_pkg::RES_SEL: begin
					acc_q   <= 1'b0;
					used_q  <= sel_q;
					mean_q  <= '0;
					count_q <= '0;
				end
				rba_pkg::RES_ACC: begin
					acc_q   <= 1'b1;
					used_q  <= dvd_q[6:0];
					mean_q  <= '0;
					count_q <= ncnt;
				end
				rba_pkg::RES_MEAN: begin
					acc_q   <= 1'b0;
					used_q  <= sel_q;
					mean_q  <= mean_c;
					count_q <= rcnt_q;
				end
				default: begin
					acc_q   <= 1'b0;
					used_q  <= '0;
					mean_q  <= '0;
					count_q <= '0;
				end
			endcase
		end
	end

	assign sts.action    = rba_pkg::action_t'(action);
	assign sts.reject    = (ri_q == ci_q) || (ssum >= 51'(lim2_q)) || (bw_q == 24'd0);
	assign sts.step_last = (step_q == 6'd0);
	assign sts.bin_over  = (dvd_q >= BINS_48);
	assign sts.sel_over  = (sel_ext >= BINS_32);
	assign sts.cnt_zero  = (rcnt_q == 32'd0);
	assign sts.clr_last  = (clr_q == LAST_BIN);

	assign accepted  = acc_q;
	assign bin_used  = used_q;
	assign bin_mean  = mean_q;
	assign bin_count = count_q;

endmodule

// ----- rtl/radial_binned_average_core.sv -----
// ----------------------------------------------------------------------------
// radial_binned_average_core
// radial profile histogram with per-bin sums, counts and mean read-back
// ----------------------------------------------------------------------------
// usage:
// an item is taken at a clock edge with start high and busy low. action
// selects accumulate, read of one bin, clear of all bins, or none (a zero
// result). every item gives exactly one result on the result ports, with
// done high for one cycle. accumulate runs difference, squares, range check,
// a 24-step bit-serial square root and a 48-step shared restoring divider,
// then a read-modify-write of the bin store. a read uses the same divider;
// an empty or out-of-range bin answers without it. a clear sweeps the bin
// store one entry a cycle, all NUM_BINS entries. one item is in flight at a
// time; busy stays high until its result is out. after reset the bin store
// is cleared by the same sweep with busy high. configuration writes land at
// once through cfg_we; the user must make them only while the block is idle,
// as the block itself does not enforce it. the receiver cannot stall results.
// ----------------------------------------------------------------------------
module radial_binned_average_core #(
	parameter int NUM_BINS = 100
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         action,
	input  logic [15:0]        row_index,
	input  logic [15:0]        col_index,
	input  logic signed [23:0] first_x,
	input  logic signed [23:0] first_y,
	input  logic signed [23:0] second_x,
	input  logic signed [23:0] second_y,
	input  logic signed [31:0] pair_value,
	input  logic [6:0]         bin_select,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [23:0]        cfg_data,
	output logic               done,
	output logic               accepted,
	output logic [6:0]         bin_used,
	output logic signed [31:0] bin_mean,
	output logic [31:0]        bin_count
);

	rba_pkg::cmd_t cmd;
	rba_pkg::sts_t sts;

	rba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	rba_datapath #(
		.NUM_BINS (NUM_BINS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (action),
		.row_index  (row_index),
		.col_index  (col_index),
		.first_x    (first_x),
		.first_y    (first_y),
		.second_x   (second_x),
		.second_y   (second_y),
		.pair_value (pair_value),
		.bin_select (bin_select),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accepted   (accepted),
		.bin_used   (bin_used),
		.bin_mean   (bin_mean),
		.bin_count  (bin_count)
	);

endmodule

// ----- rtl/rba_checker.sv -----
// ----------------------------------------------------------------------------
// rba_checker
// port-level checks on the radial binned average core
// ----------------------------------------------------------------------------
`include "radial_binned_average_core_defines.svh"

module rba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        accepted,
	input logic [31:0] bin_mean,
	input logic [31:0] bin_count
);

	`RBA_ASSERT_NEXT(a_item_progress, start && !busy, busy || done)
	`RBA_ASSERT_NOW(a_done_idle, done, !busy)
	`RBA_ASSERT_NOW(a_acc_count, done && accepted, bin_count != 32'd0)
	`RBA_ASSERT_NOW(a_acc_mean, done && accepted, bin_mean == 32'd0)

endmodule

bind radial_binned_average_core rba_checker u_rba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.accepted  (accepted),
	.bin_mean  (bin_mean),
	.bin_count (bin_count)
);
